### hdl/avr_alu_pkg.sv
// Package for the AVR ALU register block: command codes, flag bit positions
// and register file geometry. No dependencies.
`default_nettype none

package avr_alu_pkg;

  // Command codes carried on the input tuser field.
  typedef enum logic [3:0] {
    CMD_CPC    = 4'd0,
    CMD_ADD    = 4'd1,
    CMD_SBC    = 4'd2,
    CMD_MOVW   = 4'd3,
    CMD_MULS   = 4'd4,
    CMD_MULSU  = 4'd5,
    CMD_FMUL   = 4'd6,
    CMD_FMULS  = 4'd7,
    CMD_FMULSU = 4'd8,
    CMD_LDR    = 4'd9,
    CMD_LDF    = 4'd10
  } cmd_t;

  // Status flag bit positions.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;
  localparam int FLAG_W = 6;

  // Register file stored as rows of two bytes (even register in the low byte).
  localparam int RF_ROWS = 16;
  localparam int ROW_AW  = 4;

  typedef logic [15:0]       row_t;
  typedef logic [FLAG_W-1:0] flags_t;

endpackage

`default_nettype wire

### hdl/avr_alu_register_ops_top.sv
// Top level of the AVR ALU register block: register file memory, ALU and
// multiplier stage, output register. Depends on avr_alu_pkg.
`default_nettype none

// A result beat passes the memory read register, then execute and write back into
// the output register. Throughput: one beat per cycle while the output is not
// stalled, as the register file memory is read at accept and written at commit;
// a write that hits a row read in the same cycle is forwarded.
// Reset (rst_n low, synchronous) clears all flags, the row valid bits and the pipeline;
// a row that has never been written reads as zero, so no clearing pass is needed.
module avr_alu_register_ops_top
  import avr_alu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // [4:0] dest_reg, [9:5] src_reg, [17:10] load_value
  input  wire logic [3:0]  in_tuser,  // [3:0] command
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata  // [7:0] result_low, [15:8] result_high,
                                      // [21:16] status_flags
);

  // Register file: 16 rows of two bytes, read at two rows per cycle, written at one.
  row_t rf_mem [RF_ROWS];

  logic [RF_ROWS-1:0] vld_r;        // row has been written since reset
  flags_t             flags_r;

  // Execute stage registers.
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic [4:0]         s1_dest_r;
  logic [4:0]         s1_src_r;
  logic [7:0]         s1_lv_r;
  row_t               q_a_r;        // memory read data, destination row
  row_t               q_b_r;        // memory read data, source row
  logic               va_r, vb_r;   // row valid at read time
  logic               fa_r, fb_r;   // row was written in the read cycle
  row_t               fwd_data_r;

  // Output register.
  logic               out_valid_r;
  logic [23:0]        out_data_r;

  logic               in_accept;
  logic               commit;
  logic [ROW_AW-1:0]  rd_row_a, rd_row_b;

  logic               wr_en;
  logic [ROW_AW-1:0]  wr_row;
  row_t               wr_data;
  logic [7:0]         res_lo, res_hi;
  flags_t             flags_nxt;

  row_t               row_a, row_b;
  logic [7:0]         op_d, op_r;
  logic [8:0]         diff9, sum9;
  logic [7:0]         bor, cy;
  logic               a_signed, b_signed, frac;
  logic [8:0]         mul_a, mul_b;
  logic signed [17:0] prod_s;
  logic [15:0]        prod16, mul_val;

  // The execute stage moves on when the output register is free or being emptied.
  assign commit    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || commit;
  assign in_accept = in_tvalid && in_tready;

  assign rd_row_a = in_tdata[4:1];
  assign rd_row_b = in_tdata[9:6];

  // Memory: read at accept, write at commit.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_a_r <= rf_mem[rd_row_a];
      q_b_r <= rf_mem[rd_row_b];
    end
    if (wr_en) begin
      rf_mem[wr_row] <= wr_data;
    end
  end

  // Execute stage payload. A row written at the same edge as it is read is taken
  // from the write data instead of the (stale) memory output.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r   <= cmd_t'(in_tuser);
      s1_dest_r  <= in_tdata[4:0];
      s1_src_r   <= in_tdata[9:5];
      s1_lv_r    <= in_tdata[17:10];
      va_r       <= vld_r[rd_row_a];
      vb_r       <= vld_r[rd_row_b];
      fa_r       <= wr_en && (wr_row == rd_row_a);
      fb_r       <= wr_en && (wr_row == rd_row_b);
      fwd_data_r <= wr_data;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      vld_r       <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        flags_r <= flags_nxt;
      end
      if (wr_en) begin
        vld_r[wr_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {2'b00, flags_nxt, res_hi, res_lo};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Operand rows after forwarding; a row never written reads as zero.
  assign row_a = fa_r ? fwd_data_r : (va_r ? q_a_r : '0);
  assign row_b = fb_r ? fwd_data_r : (vb_r ? q_b_r : '0);
  assign op_d  = s1_dest_r[0] ? row_a[15:8] : row_a[7:0];
  assign op_r  = s1_src_r[0]  ? row_b[15:8] : row_b[7:0];

  // Subtract with carry in (CPC, SBC) and add (ADD).
  assign diff9 = {1'b0, op_d} - {1'b0, op_r} - {8'b0, flags_r[FLAG_C]};
  assign sum9  = {1'b0, op_d} + {1'b0, op_r};
  assign bor   = (~op_d & op_r) | (op_r & diff9[7:0]) | (diff9[7:0] & ~op_d);
  assign cy    = (op_d & op_r) | (op_r & ~sum9[7:0]) | (~sum9[7:0] & op_d);

  // Multiplier: both operands are widened to nine bits so that one signed
  // multiply covers signed, unsigned and mixed forms.
  assign a_signed = (s1_cmd_r != CMD_FMUL);
  assign b_signed = (s1_cmd_r == CMD_MULS) || (s1_cmd_r == CMD_FMULS);
  assign frac     = (s1_cmd_r == CMD_FMUL) || (s1_cmd_r == CMD_FMULS) ||
                    (s1_cmd_r == CMD_FMULSU);
  assign mul_a    = {a_signed & op_d[7], op_d};
  assign mul_b    = {b_signed & op_r[7], op_r};
  assign prod_s   = $signed(mul_a) * $signed(mul_b);
  assign prod16   = prod_s[15:0];
  assign mul_val  = frac ? {prod16[14:0], 1'b0} : prod16;

  always_comb begin
    res_lo    = 8'h00;
    res_hi    = 8'h00;
    flags_nxt = flags_r;
    wr_en     = 1'b0;
    wr_row    = s1_dest_r[4:1];
    wr_data   = row_a;
    case (s1_cmd_r)
      CMD_CPC, CMD_SBC: begin
        res_lo            = diff9[7:0];
        flags_nxt[FLAG_C] = bor[7];
        flags_nxt[FLAG_H] = bor[3];
        flags_nxt[FLAG_Z] = (diff9[7:0] == 8'h00) && flags_r[FLAG_Z];
        flags_nxt[FLAG_N] = diff9[7];
        flags_nxt[FLAG_V] = (op_d[7] & ~op_r[7] & ~diff9[7]) |
                            (~op_d[7] & op_r[7] & diff9[7]);
        flags_nxt[FLAG_S] = flags_nxt[FLAG_N] ^ flags_nxt[FLAG_V];
        if (s1_cmd_r == CMD_SBC) begin
          wr_en   = 1'b1;
          wr_data = s1_dest_r[0] ? {diff9[7:0], row_a[7:0]} : {row_a[15:8], diff9[7:0]};
        end
      end
      CMD_ADD: begin
        res_lo            = sum9[7:0];
        flags_nxt[FLAG_C] = cy[7];
        flags_nxt[FLAG_H] = cy[3];
        flags_nxt[FLAG_Z] = (sum9[7:0] == 8'h00);
        flags_nxt[FLAG_N] = sum9[7];
        flags_nxt[FLAG_V] = (op_d[7] & op_r[7] & ~sum9[7]) |
                            (~op_d[7] & ~op_r[7] & sum9[7]);
        flags_nxt[FLAG_S] = flags_nxt[FLAG_N] ^ flags_nxt[FLAG_V];
        wr_en             = 1'b1;
        wr_data = s1_dest_r[0] ? {sum9[7:0], row_a[7:0]} : {row_a[15:8], sum9[7:0]};
      end
      CMD_MOVW: begin
        res_lo  = row_b[7:0];
        res_hi  = row_b[15:8];
        wr_en   = 1'b1;
        wr_data = row_b;
      end
      CMD_MULS, CMD_MULSU, CMD_FMUL, CMD_FMULS, CMD_FMULSU: begin
        res_lo            = mul_val[7:0];
        res_hi            = mul_val[15:8];
        flags_nxt[FLAG_C] = prod16[15];
        flags_nxt[FLAG_Z] = (mul_val == 16'h0000);
        wr_en             = 1'b1;
        wr_row            = '0;
        wr_data           = mul_val;
      end
      CMD_LDR: begin
        res_lo  = s1_lv_r;
        wr_en   = 1'b1;
        wr_data = s1_dest_r[0] ? {s1_lv_r, row_a[7:0]} : {row_a[15:8], s1_lv_r};
      end
      CMD_LDF: begin
        flags_nxt = s1_lv_r[FLAG_W-1:0];
      end
      default: begin
      end
    endcase
    if (!commit) begin
      wr_en = 1'b0;
    end
  end

  // A product always lands in row zero, which then reads as written.
  a_mul_row0: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (s1_cmd_r == CMD_MULS || s1_cmd_r == CMD_FMUL) |=> vld_r[0])
    else $error("multiply did not mark row zero written");

  // MOVW and register loads leave the flags alone.
  a_flags_kept: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (s1_cmd_r == CMD_MOVW || s1_cmd_r == CMD_LDR) |=> flags_r == $past(flags_r))
    else $error("flags changed on a flag-neutral command");

  // A write that hits a row read in the same cycle must be forwarded.
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && wr_en && (wr_row == rd_row_a) |=> fa_r)
    else $error("missed forwarding into the destination row");

  // Arithmetic results carry a zero high byte.
  a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (s1_cmd_r == CMD_ADD || s1_cmd_r == CMD_SBC || s1_cmd_r == CMD_CPC)
    |=> out_tvalid && out_tdata[15:8] == 8'h00)
    else $error("nonzero high byte on an arithmetic result");

endmodule

`default_nettype wire

### tb/avr_alu_register_ops_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for avr_alu_register_ops_top: directed and random command
// beats, each checked against an in-bench model of the register file and flags.
// Depends on avr_alu_pkg and the avr_alu_register_ops_top RTL.
module avr_alu_register_ops_top_tb
  import avr_alu_pkg::*;
();

  // Cycles with no beat accepted on either channel before the run is abandoned.
  // Long quiet gaps at an 84 percent idle or stall rate are already vanishingly
  // unlikely, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 5000;
  // Extra cycles to wait at the end, once every result has come back.
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  // Command codes that the block does not implement.
  localparam logic [3:0] CMD_UNUSED_FIRST = 4'd11;
  localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;

  // One expected result beat, plus the command that caused it for messages.
  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] res_lo;
    logic [7:0] res_hi;
    flags_t     flags;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [4:0] dest_reg, [9:5] src_reg, [17:10] load_value
  logic [3:0]  in_tuser;   // [3:0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] result_low, [15:8] result_high, [21:16] status_flags

  // Shadow copy of the architectural state, advanced once per accepted beat.
  logic [7:0]  model_regs [32];
  flags_t      model_flags;
  alu_result_t pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int quiet_cycles;

  avr_alu_register_ops_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Computes the result of one command and advances the shadow state, in the
  // order the block executes them.
  function automatic alu_result_t execute_alu_op(input logic [3:0] cmd,
                                                 input logic [4:0] rd,
                                                 input logic [4:0] rr,
                                                 input logic [7:0] lv);
    alu_result_t r;
    flags_t      nf;
    logic [7:0]  d;
    logic [7:0]  s;
    logic [7:0]  res;
    logic [7:0]  cv;
    logic [15:0] prod;
    logic [15:0] val;
    logic [4:0]  dp;
    logic [4:0]  sp;
    int          a;
    int          b;
    r     = '0;
    r.cmd = cmd;
    d     = model_regs[rd];
    s     = model_regs[rr];
    case (cmd)
      CMD_CPC, CMD_SBC: begin
        res = d - s - 8'(model_flags[FLAG_C]);
        // Borrow out of every bit position.
        cv  = (~d & s) | (s & res) | (res & ~d);
        nf  = '0;
        nf[FLAG_C] = cv[7];
        nf[FLAG_H] = cv[3];
        // Z only survives a zero difference when it was already set.
        nf[FLAG_Z] = (res == 8'h00) && model_flags[FLAG_Z];
        nf[FLAG_N] = res[7];
        nf[FLAG_V] = (d[7] & ~s[7] & ~res[7]) | (~d[7] & s[7] & res[7]);
        nf[FLAG_S] = nf[FLAG_N] ^ nf[FLAG_V];
        model_flags = nf;
        if (cmd == CMD_SBC) begin
          model_regs[rd] = res;
        end
        r.res_lo = res;
      end
      CMD_ADD: begin
        res = d + s;
        cv  = (d & s) | (s & ~res) | (~res & d);
        nf  = '0;
        nf[FLAG_C] = cv[7];
        nf[FLAG_H] = cv[3];
        nf[FLAG_Z] = (res == 8'h00);
        nf[FLAG_N] = res[7];
        nf[FLAG_V] = (d[7] & s[7] & ~res[7]) | (~d[7] & ~s[7] & res[7]);
        nf[FLAG_S] = nf[FLAG_N] ^ nf[FLAG_V];
        model_flags    = nf;
        model_regs[rd] = res;
        r.res_lo       = res;
      end
      CMD_MOVW: begin
        dp       = {rd[4:1], 1'b0};
        sp       = {rr[4:1], 1'b0};
        r.res_lo = model_regs[sp];
        r.res_hi = model_regs[sp | 5'd1];
        model_regs[dp]         = r.res_lo;
        model_regs[dp | 5'd1]  = r.res_hi;
      end
      CMD_MULS, CMD_MULSU, CMD_FMUL, CMD_FMULS, CMD_FMULSU: begin
        // Only FMUL takes Rd unsigned; only MULS and FMULS take Rr signed.
        a    = (cmd == CMD_FMUL) ? int'(d) : int'($signed(d));
        b    = (cmd == CMD_MULS || cmd == CMD_FMULS) ? int'($signed(s)) : int'(s);
        prod = 16'(a * b);
        val  = (cmd == CMD_FMUL || cmd == CMD_FMULS || cmd == CMD_FMULSU) ?
               {prod[14:0], 1'b0} : prod;
        // Carry comes from the unshifted product; N, V, S and H are kept.
        model_flags[FLAG_C] = prod[15];
        model_flags[FLAG_Z] = (val == 16'h0000);
        model_regs[0] = val[7:0];
        model_regs[1] = val[15:8];
        r.res_lo = val[7:0];
        r.res_hi = val[15:8];
      end
      CMD_LDR: begin
        model_regs[rd] = lv;
        r.res_lo       = lv;
      end
      CMD_LDF: begin
        model_flags = lv[5:0];
      end
      default: begin
      end
    endcase
    r.flags = model_flags;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Result checking and the watchdog share one sampling point at the rising edge.
  // Output beats are checked before the input beat of the same edge is modeled;
  // with the memory read and execute registers between them the two never refer to each other.
  always @(posedge clk) begin : result_check
    alu_result_t want;
    logic        progress;
    progress = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        progress = 1'b1;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result beat %h with no command outstanding", out_tdata));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[7:0] !== want.res_lo || out_tdata[15:8] !== want.res_hi ||
              out_tdata[21:16] !== want.flags) begin
            note_failure($sformatf(
              "cmd %0d: expected lo %h hi %h flags %b, got lo %h hi %h flags %b",
              want.cmd, want.res_lo, want.res_hi, want.flags,
              out_tdata[7:0], out_tdata[15:8], out_tdata[21:16]));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        progress = 1'b1;
        pending_results.push_back(execute_alu_op(in_tuser, in_tdata[4:0], in_tdata[9:5],
                                                 in_tdata[17:10]));
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: stalls at the rate of the current phase, decided anew every cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one command beat. Idle cycles come first, so a valid that stays up for
  // back-to-back beats is never dropped and raised within the same step.
  task automatic send_beat(input logic [3:0] cmd, input logic [4:0] rd,
                           input logic [4:0] rr, input logic [7:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, lv, rr, rd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Loads the operands used by the directed tests; the flag load sets every flag
  // and carries ones in the two ignored upper bits.
  task automatic test_register_loads();
    send_beat(CMD_LDR, 5'd31, 5'd0, 8'hFF);
    send_beat(CMD_LDR, 5'd16, 5'd0, 8'h80);
    send_beat(CMD_LDR, 5'd17, 5'd0, 8'h7F);
    send_beat(CMD_LDR, 5'd2,  5'd0, 8'h01);
    send_beat(CMD_LDR, 5'd3,  5'd0, 8'hFF);
    send_beat(CMD_LDF, 5'd0,  5'd0, 8'hFF);
  endtask

  // Carry-in, zero chaining in CPC and SBC, overflow and half carry in ADD.
  task automatic test_add_subtract();
    // Equal operands with carry in: the difference is nonzero, so Z drops.
    send_beat(CMD_CPC, 5'd31, 5'd31, 8'h00);
    // Z set, C clear, then a zero difference keeps Z.
    send_beat(CMD_LDF, 5'd0,  5'd0,  8'h02);
    send_beat(CMD_CPC, 5'd16, 5'd16, 8'h00);
    // 0x7F + 1 overflows into the sign bit.
    send_beat(CMD_ADD, 5'd17, 5'd2,  8'h00);
    // 0xFF + 1 wraps to zero with carry and half carry.
    send_beat(CMD_ADD, 5'd31, 5'd2,  8'h00);
    // Positive minus negative with borrow in overflows.
    send_beat(CMD_SBC, 5'd2,  5'd16, 8'h00);
    send_beat(CMD_SBC, 5'd0,  5'd0,  8'h00);
  endtask

  // Odd indices must address the even register of the pair.
  task automatic test_register_pair_move();
    send_beat(CMD_MOVW, 5'd5,  5'd17, 8'h00);
    send_beat(CMD_MOVW, 5'd31, 5'd30, 8'h00);
  endtask

  // Most negative and largest unsigned operands for each signedness mix, and a
  // multiply that reads the previous product out of R1:R0.
  task automatic test_multiplies();
    send_beat(CMD_MULS,   5'd16, 5'd4,  8'h00);
    send_beat(CMD_MULSU,  5'd16, 5'd5,  8'h00);
    send_beat(CMD_FMUL,   5'd5,  5'd5,  8'h00);
    send_beat(CMD_FMULS,  5'd16, 5'd16, 8'h00);
    send_beat(CMD_FMULSU, 5'd16, 5'd3,  8'h00);
    send_beat(CMD_MULS,   5'd0,  5'd1,  8'h00);
  endtask

  // Unimplemented codes change nothing but still return one beat.
  task automatic test_unused_commands();
    send_beat(CMD_UNUSED_FIRST, 5'd31, 5'd0,  8'hFF);
    send_beat(CMD_UNUSED_LAST,  5'd0,  5'd31, 8'h00);
  endtask

  // Random commands at the given idle and stall rates. Half the indices are kept
  // to R0..R3 so operands repeat, products are read back and zero results occur.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    logic [3:0] cmd;
    logic [4:0] rd;
    logic [4:0] rr;
    logic [7:0] lv;
    int         pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 14) begin
        cmd = CMD_LDR;
      end else if (pick < 20) begin
        cmd = CMD_LDF;
      end else if (pick < 23) begin
        cmd = 4'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      end else begin
        cmd = 4'($urandom_range(CMD_FMULSU, CMD_CPC));
      end
      rd = $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
      rr = $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
      case ($urandom_range(3))
        0:       lv = 8'h00;
        1:       lv = 8'hFF;
        default: lv = 8'($urandom_range(255));
      endcase
      send_beat(cmd, rd, rr, lv);
    end
  endtask

  // The sender holds off until every outstanding result has come back, then
  // resumes against a heavily stalling receiver.
  task automatic test_pause_until_drained();
    test_random_traffic(12, 0, 84);
    stop_sending();
    wait_drained();
    test_random_traffic(12, 0, 84);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    model_flags    = '0;
    foreach (model_regs[i]) model_regs[i] = 8'h00;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_loads();
    test_add_subtract();
    test_register_pair_move();
    test_multiplies();
    test_unused_commands();
    test_random_traffic(200, 0, 0);
    test_random_traffic(170, 84, 0);
    test_random_traffic(170, 0, 84);
    test_pause_until_drained();
    test_random_traffic(170, 17, 17);

    stop_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/avr_alu_pkg.sv
hdl/avr_alu_register_ops_top.sv
tb/avr_alu_register_ops_top_tb.sv
